### src/biq_pkg.sv
// Shared constants for the biquad low-pass filter: register indexes,
// mode codes, coefficient slots and default widths. No dependencies.
`timescale 1ns / 1ps

package biq_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF   = 20;

  localparam int CFG_INDEX_W = 3;
  localparam int MODE_W      = 2;
  localparam int NUM_COEF    = 5;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_FEED_ZERO = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_FEED_ONE  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_FEED_TWO  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_BACK_ONE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_BACK_TWO  = 3'd5;

  // Mode codes; any other code mutes
  localparam logic [MODE_W-1:0] MODE_FILTER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BYPASS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MUTE   = 2'd2;

  // Slots in the packed coefficient vector
  localparam int COEF_FEED_ZERO = 0;
  localparam int COEF_FEED_ONE  = 1;
  localparam int COEF_FEED_TWO  = 2;
  localparam int COEF_BACK_ONE  = 3;
  localparam int COEF_BACK_TWO  = 4;

endpackage

### src/biq_cfg_regs.sv
// Configuration register file for the biquad: filter mode and five Q2 coefficients.
// Depends on biq_pkg for register indexes, mode codes and coefficient slots.
`timescale 1ns / 1ps

module biq_cfg_regs
  import biq_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [CFG_INDEX_W-1:0]             wr_index,
  input  logic [COEF_WIDTH-1:0]              wr_data,
  output logic [MODE_W-1:0]                  mode,
  output logic [NUM_COEF-1:0][COEF_WIDTH-1:0] coef
);

  logic [MODE_W-1:0]                   mode_r;
  logic [NUM_COEF-1:0][COEF_WIDTH-1:0] coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BYPASS;
      coef_r <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_FILTER_MODE:    mode_r                 <= wr_data[MODE_W-1:0];
        REG_COEF_FEED_ZERO: coef_r[COEF_FEED_ZERO] <= wr_data;
        REG_COEF_FEED_ONE:  coef_r[COEF_FEED_ONE]  <= wr_data;
        REG_COEF_FEED_TWO:  coef_r[COEF_FEED_TWO]  <= wr_data;
        REG_COEF_BACK_ONE:  coef_r[COEF_BACK_ONE]  <= wr_data;
        REG_COEF_BACK_TWO:  coef_r[COEF_BACK_TWO]  <= wr_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign mode = mode_r;
  assign coef = coef_r;

endmodule

### src/biq_core.sv
// Biquad arithmetic: five parallel products, exact sum, round and saturate,
// plus the direct form I history registers. Depends on biq_pkg.
`timescale 1ns / 1ps

module biq_core
  import biq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step_en,
  input  logic [MODE_W-1:0]                  mode,
  input  logic [NUM_COEF-1:0][COEF_WIDTH-1:0] coef,
  input  logic [SAMPLE_WIDTH-1:0]            x_in,
  output logic [SAMPLE_WIDTH-1:0]            y_out
);

  localparam int FRAC_BITS = COEF_WIDTH - 2;
  localparam int PROD_W    = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W     = PROD_W + 3;
  localparam int Q_W       = ACC_W - FRAC_BITS;
  localparam int TOP_W     = Q_W - SAMPLE_WIDTH + 1;
  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0] x1_r, x2_r, y1_r, y2_r;
  logic signed [SAMPLE_WIDTH-1:0] x_s;
  logic signed [COEF_WIDTH-1:0]   c_fz, c_f1, c_f2, c_b1, c_b2;
  logic signed [PROD_W-1:0]       p_fz, p_f1, p_f2, p_b1, p_b2;
  logic signed [ACC_W-1:0]        acc, acc_rnd;
  logic        [Q_W-1:0]          q;
  logic        [TOP_W-1:0]        q_top;
  logic        [SAMPLE_WIDTH-1:0] y_filt;
  logic                           filt_step;

  assign x_s  = signed'(x_in);
  assign c_fz = signed'(coef[COEF_FEED_ZERO]);
  assign c_f1 = signed'(coef[COEF_FEED_ONE]);
  assign c_f2 = signed'(coef[COEF_FEED_TWO]);
  assign c_b1 = signed'(coef[COEF_BACK_ONE]);
  assign c_b2 = signed'(coef[COEF_BACK_TWO]);

  assign p_fz = c_fz * x_s;
  assign p_f1 = c_f1 * x1_r;
  assign p_f2 = c_f2 * x2_r;
  assign p_b1 = c_b1 * y1_r;
  assign p_b2 = c_b2 * y2_r;

  assign acc = ACC_W'(p_fz) + ACC_W'(p_f1) + ACC_W'(p_f2)
             + ACC_W'(p_b1) + ACC_W'(p_b2);
  // round half up, then floor by dropping the fraction
  assign acc_rnd = acc + HALF;
  assign q       = acc_rnd[ACC_W-1:FRAC_BITS];
  assign q_top   = q[Q_W-1:SAMPLE_WIDTH-1];

  always_comb begin
    if ((&q_top) || !(|q_top)) begin
      y_filt = q[SAMPLE_WIDTH-1:0];
    end else begin
      y_filt = {q[Q_W-1], {(SAMPLE_WIDTH-1){~q[Q_W-1]}}};
    end
  end

  always_comb begin
    case (mode)
      MODE_FILTER: y_out = y_filt;
      MODE_BYPASS: y_out = x_in;
      default:     y_out = '0;
    endcase
  end

  assign filt_step = step_en && (mode == MODE_FILTER);

  // advance the delay lines only on a filtered sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (filt_step) begin
      x2_r <= x1_r;
      x1_r <= x_s;
      y2_r <= y1_r;
      y1_r <= signed'(y_filt);
    end
  end

  a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !filt_step |=> $stable(x1_r) && $stable(x2_r) && $stable(y1_r) && $stable(y2_r))
    else $error("history changed outside filter mode");

  a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
    filt_step |=> (x2_r == $past(x1_r)) && (y2_r == $past(y1_r)) && (x1_r == $past(x_s)))
    else $error("delay line did not shift in order");

endmodule

### src/biquad_lowpass_filter_top.sv
// Biquad low-pass filter, direct form I: one input register, one pass of
// arithmetic, one result register. Depends on biq_pkg, biq_cfg_regs, biq_core.
//
// Usage:
//   Input channel  in_valid / in_stall / in_sample_in: a sample is taken at a
//   rising edge where in_valid is high and in_stall is low.
//   Result channel out_valid / out_stall / out_sample_out: one result per
//   sample, taken at an edge where out_valid is high and out_stall is low.
//   Config channel cfg_valid / cfg_ready / cfg_index / cfg_wdata: register 0 is
//   the mode (0 filter, 1 bypass, 2 mute), 1..5 the Q2 coefficients a0, a1,
//   a2, b1, b2. Write only while no samples are in flight. cfg_ready is
//   always high.
//   A sample moves from the input register into the result register when the
//   result register is free; out_valid rises as the result register loads it.
//   Throughput: one sample per cycle while out_stall is low; the combinational
//   multiply-accumulate that feeds the output history sets this rate.
//   Reset (rst_n low, synchronous) empties both registers, clears the
//   history and coefficients and selects bypass mode.
//   A stalled result holds; the input register still takes one more sample,
//   then in_stall rises until the result is taken.
`timescale 1ns / 1ps

module biquad_lowpass_filter_top
  import biq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SAMPLE_WIDTH-1:0] out_sample_out,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [COEF_WIDTH-1:0]   cfg_wdata
);

  logic                               s_valid_r;
  logic [SAMPLE_WIDTH-1:0]            s_x_r;
  logic                               out_valid_r;
  logic [SAMPLE_WIDTH-1:0]            out_sample_r;
  logic                               advance;
  logic [MODE_W-1:0]                  mode;
  logic [NUM_COEF-1:0][COEF_WIDTH-1:0] coef;
  logic [SAMPLE_WIDTH-1:0]            y;

  assign cfg_ready = 1'b1;

  biq_cfg_regs #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .mode     (mode),
    .coef     (coef)
  );

  biq_core #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s_valid_r & advance),
    .mode    (mode),
    .coef    (coef),
    .x_in    (s_x_r),
    .y_out   (y)
  );

  // result register frees up when empty or taken this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s_x_r <= in_sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s_valid_r) begin
      out_sample_r <= y;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r && advance |=> out_valid_r)
    else $error("transaction lost between input and result register");

  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r && advance && (mode == MODE_BYPASS) |=> out_sample_r == $past(s_x_r))
    else $error("bypass result differs from input sample");

  a_mute: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r && advance && (mode != MODE_FILTER) && (mode != MODE_BYPASS)
    |=> out_sample_r == '0)
    else $error("mute result is not zero");

endmodule

### dv/tb_top.sv
// Self-checking testbench for the biquad low-pass filter: directed and random
// samples over several register settings, checked against an in-bench predictor.
// Depends on biq_pkg and biquad_lowpass_filter_top.
`timescale 1ns / 1ps

module tb_top
  import biq_pkg::*;
();

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int CW = COEF_WIDTH_DEF;
  localparam int FRAC_BITS = CW - 2;
  localparam longint SAMPLE_MAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SAMPLE_MIN = -(longint'(1) <<< (SW - 1));
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam logic signed [CW-1:0] COEF_ONE = 20'sd262144;
  localparam logic signed [CW-1:0] COEF_HALF = 20'sd131072;
  localparam logic signed [CW-1:0] COEF_MAX = 20'sh7FFFF;
  localparam logic signed [CW-1:0] COEF_MIN = 20'sh80000;
  localparam int DRAIN_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 880;

  typedef logic signed [CW-1:0] coef_set_t [NUM_COEF];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SW-1:0] in_sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SW-1:0] out_sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_wdata = '0;

  // Predictor state: mirrored registers and delay lines
  logic [MODE_W-1:0] mode_mirror = MODE_BYPASS;
  coef_set_t coef_mirror = '{default: '0};
  logic signed [SW-1:0] hist_x1 = '0;
  logic signed [SW-1:0] hist_x2 = '0;
  logic signed [SW-1:0] hist_y1 = '0;
  logic signed [SW-1:0] hist_y2 = '0;

  logic [SW-1:0] predicted_outputs[$];

  bit sender_gaps = 1'b1;
  bit receiver_gaps = 1'b1;
  int hold_request = 0;
  int stall_left = 0;
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int settings_loaded = 0;
  int input_stall_cycles = 0;
  int long_holds = 0;

  biquad_lowpass_filter_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("tb_top: MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Direct form I step: exact sum, round half up, saturate, shift history
  function automatic logic [SW-1:0] biquad_step(input logic signed [SW-1:0] x);
    longint acc;
    longint rounded;
    logic signed [SW-1:0] y;
    case (mode_mirror)
      MODE_FILTER: begin
        acc = longint'(coef_mirror[COEF_FEED_ZERO]) * longint'(x)
            + longint'(coef_mirror[COEF_FEED_ONE]) * longint'(hist_x1)
            + longint'(coef_mirror[COEF_FEED_TWO]) * longint'(hist_x2)
            + longint'(coef_mirror[COEF_BACK_ONE]) * longint'(hist_y1)
            + longint'(coef_mirror[COEF_BACK_TWO]) * longint'(hist_y2);
        rounded = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (rounded > SAMPLE_MAX) rounded = SAMPLE_MAX;
        if (rounded < SAMPLE_MIN) rounded = SAMPLE_MIN;
        y = SW'(rounded);
        hist_x2 = hist_x1;
        hist_x1 = x;
        hist_y2 = hist_y1;
        hist_y1 = y;
      end
      MODE_BYPASS: y = x;
      default: y = '0;
    endcase
    return y;
  endfunction

  // Leaves cfg_valid high; load_config lowers it after the last write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FILTER_MODE: mode_mirror = data[MODE_W-1:0];
      REG_COEF_FEED_ZERO: coef_mirror[COEF_FEED_ZERO] = data;
      REG_COEF_FEED_ONE: coef_mirror[COEF_FEED_ONE] = data;
      REG_COEF_FEED_TWO: coef_mirror[COEF_FEED_TWO] = data;
      REG_COEF_BACK_ONE: coef_mirror[COEF_BACK_ONE] = data;
      REG_COEF_BACK_TWO: coef_mirror[COEF_BACK_TWO] = data;
      default: ;
    endcase
  endtask

  // Mode goes in with random upper bits; the two spare indexes get junk
  task automatic load_config(input logic [MODE_W-1:0] mode, input coef_set_t coefs);
    write_reg(REG_FILTER_MODE, {(CW - MODE_W)'($urandom), mode});
    write_reg(REG_COEF_FEED_ZERO, coefs[COEF_FEED_ZERO]);
    write_reg(REG_COEF_FEED_ONE, coefs[COEF_FEED_ONE]);
    write_reg(REG_COEF_FEED_TWO, coefs[COEF_FEED_TWO]);
    write_reg(REG_COEF_BACK_ONE, coefs[COEF_BACK_ONE]);
    write_reg(REG_COEF_BACK_TWO, coefs[COEF_BACK_TWO]);
    write_reg(REG_UNUSED_LO, CW'($urandom));
    write_reg(REG_UNUSED_HI, CW'($urandom));
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  task automatic send_sample(input logic [SW-1:0] value);
    in_valid <= 1'b1;
    in_sample_in <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_outputs.push_back(biquad_step(value));
    items_sent++;
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Hold the sender until every outstanding transaction has come back
  task automatic wait_drained();
    int spins;
    spins = 0;
    in_valid <= 1'b0;
    while (predicted_outputs.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (3) @(posedge clk);
    if (predicted_outputs.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", predicted_outputs.size()));
      predicted_outputs.delete();
    end
  endtask

  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return SW'(int'($urandom_range(0, 511)) - 256);
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic coef_set_t lowpass_coefs();
    coef_set_t c;
    int gain;
    gain = $urandom_range(200, 20000);
    c[COEF_FEED_ZERO] = CW'(gain);
    c[COEF_FEED_ONE] = CW'(2 * gain);
    c[COEF_FEED_TWO] = CW'(gain);
    c[COEF_BACK_ONE] = CW'($urandom_range(262144, 500000));
    c[COEF_BACK_TWO] = CW'(-int'($urandom_range(60000, 240000)));
    return c;
  endfunction

  function automatic coef_set_t random_coefs();
    coef_set_t c;
    for (int i = 0; i < NUM_COEF; i++) begin
      case ($urandom_range(0, 5))
        0: c[i] = COEF_MAX;
        1: c[i] = COEF_MIN;
        2: c[i] = CW'(int'($urandom_range(0, 131072)) - 65536);
        default: c[i] = CW'($urandom);
      endcase
    end
    return c;
  endfunction

  // Receiver: random stall bursts, plus long holds on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
        long_holds++;
      end else if (stall_left == 0 && receiver_gaps && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker: every accepted transaction against the oldest prediction
  always @(posedge clk) begin : check_results
    logic [SW-1:0] want;
    if (rst_n && in_valid && in_stall) input_stall_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected sample_out %0d", $signed(out_sample_out)));
      end else begin
        want = predicted_outputs.pop_front();
        if (out_sample_out !== want)
          report_mismatch($sformatf("sample_out got %0d want %0d",
                                    $signed(out_sample_out), $signed(want)));
        results_checked++;
      end
    end
  end

  // Reset leaves bypass with zero coefficients; no register written yet
  task automatic test_reset_state();
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    wait_drained();
  endtask

  task automatic test_mute_modes();
    load_config(MODE_MUTE, lowpass_coefs());
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    wait_drained();
    load_config(MODE_SPARE, random_coefs());
    send_sample(16'h04D2);
    send_sample(16'hFFFF);
    wait_drained();
  endtask

  // Half gain lands exactly on halves: they must round upward
  task automatic test_rounding();
    coef_set_t c;
    c = '{default: '0};
    c[COEF_FEED_ZERO] = COEF_HALF;
    load_config(MODE_FILTER, c);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'h0003);
    send_sample(16'hFFFD);
    send_sample(16'h7FFF);
    wait_drained();
  endtask

  task automatic test_saturation();
    coef_set_t c;
    c = '{default: COEF_MAX};
    load_config(MODE_FILTER, c);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h8000);
    wait_drained();
    c = '{default: COEF_MIN};
    load_config(MODE_FILTER, c);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    wait_drained();
  endtask

  // Unit gain on x1 only: bypass in between must not shift the history
  task automatic test_history_hold();
    coef_set_t c;
    c = '{default: '0};
    c[COEF_FEED_ONE] = COEF_ONE;
    load_config(MODE_FILTER, c);
    send_sample(16'd100);
    wait_drained();
    load_config(MODE_BYPASS, c);
    send_sample(16'd7);
    wait_drained();
    load_config(MODE_FILTER, c);
    send_sample(16'd200);
    wait_drained();
  endtask

  task automatic test_random_streams();
    int stop_at;
    int burst;
    logic [MODE_W-1:0] mode;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: mode = MODE_BYPASS;
        1: mode = MODE_MUTE;
        2: mode = MODE_SPARE;
        default: mode = MODE_FILTER;
      endcase
      load_config(mode, ($urandom_range(0, 2) == 0) ? random_coefs() : lowpass_coefs());
      burst = $urandom_range(30, 120);
      repeat (burst) send_sample(rand_sample());
      wait_drained();
    end
  endtask

  // Long receiver hold with the sender pushing until the input stalls
  task automatic test_backpressure();
    load_config(MODE_FILTER, lowpass_coefs());
    sender_gaps = 1'b0;
    hold_request = 80;
    repeat (40) send_sample(rand_sample());
    sender_gaps = 1'b1;
    wait_drained();
  endtask

  task automatic test_full_rate();
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    load_config(MODE_FILTER, lowpass_coefs());
    repeat (80) send_sample(rand_sample());
    wait_drained();
    load_config(MODE_FILTER, random_coefs());
    repeat (70) send_sample(rand_sample());
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_mute_modes();
    test_rounding();
    test_saturation();
    test_history_hold();
    test_random_streams();
    test_backpressure();
    test_full_rate();
    $display("tb_top: %0d samples sent, %0d results checked over %0d register settings",
             items_sent, results_checked, settings_loaded);
    $display("tb_top: input stalled %0d cycles, %0d long output holds",
             input_stall_cycles, long_holds);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_top: timeout after %0t", $time);
    $display("tb_top: errors");
    $finish;
  end

endmodule
